// File: rtl/gsr_pkg.sv
// Shared types and codes for the game-pad shift register block.
package gsr_pkg;

  // Item kinds, carried on s_tuser
  typedef enum logic [1:0] {
    FUNC_EVENT  = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_STROBE = 2'd3
  } func_t;

  // Button codes
  localparam logic [3:0] BTN_A      = 4'd0;
  localparam logic [3:0] BTN_B      = 4'd1;
  localparam logic [3:0] BTN_SELECT = 4'd2;
  localparam logic [3:0] BTN_START  = 4'd3;
  localparam logic [3:0] BTN_UP     = 4'd4;
  localparam logic [3:0] BTN_DOWN   = 4'd5;
  localparam logic [3:0] BTN_LEFT   = 4'd6;
  localparam logic [3:0] BTN_RIGHT  = 4'd7;
  localparam logic [3:0] BTN_TURBO_A = 4'd8;
  localparam logic [3:0] BTN_TURBO_B = 4'd9;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYBACK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_OPP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_DOUBLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURBO_A_PER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURBO_B_PER  = 3'd4;

  localparam logic [7:0] TURBO_PERIOD_RESET = 8'd2;

  // Bit positions in the output tdata
  localparam int unsigned OUT_READ_BIT = 0;
  localparam int unsigned OUT_MATCHED  = 1;

endpackage

// File: rtl/gamepad_shift_register_core.sv
// Game-pad port shift register: button state, turbo units and serial report.
// Usage:
//   Input items arrive on the s_ stream. s_tuser carries the item kind
//   (button event, frame tick, serial read, strobe write); s_tdata carries
//   the button code, level, DMA collision flag and strobe value.
//   Every input item produces exactly one result on the m_ stream: the
//   serial read bit (zero for non-read items) and the event-matched flag.
//   Configuration registers are written through the cfg_ channel, which is
//   always ready; write only while no transfer is in flight.
// Throughput:
//   One item per clock sustained while the receiver does not stall; all
//   state updates are a single pass of logic feeding the state and result
//   registers. The result register is the only buffer.
// Stall behavior:
//   s_tready = !m_tvalid | m_tready, so a new item is taken in the same
//   cycle the previous result is transferred. While the receiver stalls the
//   result holds and s_tready stays low.
// Reset:
//   rst (synchronous, active high) clears all state, restores the default
//   configuration (turbo periods 2) and empties the result register.
module gamepad_shift_register_core
  import gsr_pkg::*;
#(
  parameter int unsigned REPORT_LENGTH = 24  // serial report length, 8..32
) (
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [3:0] button, [4] pressed,
                                          // [5] dma_collision, [6] strobe_value
  input  logic [1:0]           s_tuser,   // [1:0] func
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [0] read_bit, [1] event_matched
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam logic [4:0] MaxIndex = 5'(REPORT_LENGTH - 1);

  // configuration
  logic       playback_mode;
  logic       allow_opposite_directions;
  logic       double_read_disabled;
  logic [7:0] turbo_a_period;
  logic [7:0] turbo_b_period;

  // block state
  logic [7:0] button_bits,   button_bits_next;
  logic [4:0] read_index,    read_index_next;
  logic       strobe_bit,    strobe_bit_next;
  logic       turbo_a_on,    turbo_a_on_next;
  logic       turbo_b_on,    turbo_b_on_next;
  logic [7:0] turbo_a_count, turbo_a_count_next;
  logic [7:0] turbo_b_count, turbo_b_count_next;

  // input fields
  func_t      func;
  logic [3:0] button;
  logic       pressed;
  logic       dma_collision;
  logic       strobe_value;

  logic       accept;
  logic       rd_bit;
  logic       matched;

  // serial read path: up to two shifts
  logic [4:0] idx_b, idx_c;
  logic       bit_a, bit_b;
  logic       second_shift;

  // turbo counters
  logic [8:0] ta_sum, tb_sum;

  assign func          = func_t'(s_tuser);
  assign button        = s_tdata[3:0];
  assign pressed       = s_tdata[4];
  assign dma_collision = s_tdata[5];
  assign strobe_value  = s_tdata[6];

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Report bits past the eight buttons read as pressed.
  assign bit_a = (read_index < 5'd8) ? button_bits[read_index[2:0]] : 1'b1;
  assign idx_b = (!strobe_bit && read_index < MaxIndex) ? read_index + 5'd1 : read_index;
  assign bit_b = (idx_b < 5'd8) ? button_bits[idx_b[2:0]] : 1'b1;
  assign idx_c = (!strobe_bit && idx_b < MaxIndex) ? idx_b + 5'd1 : idx_b;
  assign second_shift = dma_collision && !double_read_disabled;

  assign ta_sum = {1'b0, turbo_a_count} + 9'd1;
  assign tb_sum = {1'b0, turbo_b_count} + 9'd1;

  always_comb begin
    button_bits_next   = button_bits;
    read_index_next    = read_index;
    strobe_bit_next    = strobe_bit;
    turbo_a_on_next    = turbo_a_on;
    turbo_b_on_next    = turbo_b_on;
    turbo_a_count_next = turbo_a_count;
    turbo_b_count_next = turbo_b_count;
    rd_bit             = 1'b0;
    matched            = 1'b1;

    case (func)
      FUNC_EVENT: begin
        if (!playback_mode) begin
          case (button)
            BTN_A: begin
              if (!turbo_a_on) button_bits_next[0] = pressed;
            end
            BTN_B: begin
              if (!turbo_b_on) button_bits_next[1] = pressed;
            end
            BTN_SELECT, BTN_START: begin
              button_bits_next[button[2:0]] = pressed;
            end
            BTN_UP, BTN_DOWN, BTN_LEFT, BTN_RIGHT: begin
              button_bits_next[button[2:0]] = pressed;
              // a press frees the opposite (up/down, left/right) unless allowed
              if (!allow_opposite_directions && pressed)
                button_bits_next[{button[2:1], ~button[0]}] = 1'b0;
            end
            BTN_TURBO_A: begin
              turbo_a_on_next = pressed;
              if (!pressed) begin
                button_bits_next[0] = 1'b0;
                turbo_a_count_next  = 8'd0;
              end
            end
            BTN_TURBO_B: begin
              turbo_b_on_next = pressed;
              if (!pressed) begin
                button_bits_next[1] = 1'b0;
                turbo_b_count_next  = 8'd0;
              end
            end
            default: begin
              matched = 1'b0;
            end
          endcase
        end
      end
      FUNC_TICK: begin
        if (turbo_a_on) begin
          if (ta_sum == {1'b0, turbo_a_period}) begin
            button_bits_next[0] = 1'b1;
            turbo_a_count_next  = ta_sum[7:0];
          end else if (ta_sum > {1'b0, turbo_a_period}) begin
            button_bits_next[0] = 1'b0;
            turbo_a_count_next  = 8'd0;
          end else begin
            turbo_a_count_next  = ta_sum[7:0];
          end
        end
        if (turbo_b_on) begin
          if (tb_sum == {1'b0, turbo_b_period}) begin
            button_bits_next[1] = 1'b1;
            turbo_b_count_next  = tb_sum[7:0];
          end else if (tb_sum > {1'b0, turbo_b_period}) begin
            button_bits_next[1] = 1'b0;
            turbo_b_count_next  = 8'd0;
          end else begin
            turbo_b_count_next  = tb_sum[7:0];
          end
        end
      end
      FUNC_READ: begin
        if (second_shift) begin
          rd_bit          = bit_b;
          read_index_next = idx_c;
        end else begin
          rd_bit          = bit_a;
          read_index_next = idx_b;
        end
      end
      FUNC_STROBE: begin
        strobe_bit_next = strobe_value;
        read_index_next = 5'd0;
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      playback_mode             <= 1'b0;
      allow_opposite_directions <= 1'b0;
      double_read_disabled      <= 1'b0;
      turbo_a_period            <= TURBO_PERIOD_RESET;
      turbo_b_period            <= TURBO_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PLAYBACK:    playback_mode             <= cfg_data[0];
        CFG_ALLOW_OPP:   allow_opposite_directions <= cfg_data[0];
        CFG_NO_DOUBLE:   double_read_disabled      <= cfg_data[0];
        CFG_TURBO_A_PER: turbo_a_period            <= cfg_data;
        CFG_TURBO_B_PER: turbo_b_period            <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // block state, updated on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      button_bits   <= 8'd0;
      read_index    <= 5'd0;
      strobe_bit    <= 1'b0;
      turbo_a_on    <= 1'b0;
      turbo_b_on    <= 1'b0;
      turbo_a_count <= 8'd0;
      turbo_b_count <= 8'd0;
    end else if (accept) begin
      button_bits   <= button_bits_next;
      read_index    <= read_index_next;
      strobe_bit    <= strobe_bit_next;
      turbo_a_on    <= turbo_a_on_next;
      turbo_b_on    <= turbo_b_on_next;
      turbo_a_count <= turbo_a_count_next;
      turbo_b_count <= turbo_b_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // [1] event_matched, [0] read_bit
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {6'd0, matched, rd_bit};
    end
  end

endmodule

// File: rtl/gsr_checker.sv
// Port-level assertions for the game-pad shift register, bound to the top level.
module gsr_checker
  import gsr_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [1:0]           s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [7:0]           m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // every input transfer shows a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("no result after input transfer");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // only a serial read can return a set data bit
  a_bit_only_on_read: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != FUNC_READ |=> !m_tdata[OUT_READ_BIT])
    else $error("read bit set for non-read item");

  // non-event items are always matched
  a_matched_non_event: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != FUNC_EVENT |=> m_tdata[OUT_MATCHED])
    else $error("non-event item reported unmatched");

endmodule

bind gamepad_shift_register_core gsr_checker u_gsr_checker (.*);
